// ===== rtl/btpt_pkg.sv =====
`default_nettype none
package btpt_pkg;

    localparam int NODE_POOL = 1024;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int ADDR_BITS = 32;
    localparam int LEN_W     = 6;
    localparam int CODE_W    = 5;
    localparam int ACT_W     = 6;
    localparam int STAT_W    = 2;
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] child0;
        logic [IDX_W-1:0] child1;
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] parent;
    } t_node;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_node            wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_node_ctl;

    typedef struct packed {
        logic             clr_we;
        logic [IDX_W-1:0] clr_idx;
        logic             pop_rd;
        logic             pop;
        logic             push;
        logic [IDX_W-1:0] push_data;
    } t_free_ctl;

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_WALK     = 9'b000000100,
        S_POP      = 9'b000001000,
        S_ALLOC    = 9'b000010000,
        S_ADD_FIN  = 9'b000100000,
        S_PRUNE    = 9'b001000000,
        S_PRUNE_UP = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/btpt_node_store.sv =====
`default_nettype none
module btpt_node_store (
    input  wire              i_clk,
    input  btpt_pkg::t_node_ctl i_ctl,
    output btpt_pkg::t_node  o_rdata
);

    btpt_pkg::t_node r_mem [btpt_pkg::NODE_POOL];
    btpt_pkg::t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_ctl.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/btpt_free_stack.sv =====
`default_nettype none
module btpt_free_stack (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  btpt_pkg::t_free_ctl            i_ctl,
    output logic [btpt_pkg::IDX_W-1:0]     o_rd_data,
    output logic [btpt_pkg::CNT_W-1:0]     o_top
);

    logic [btpt_pkg::IDX_W-1:0] r_mem [btpt_pkg::NODE_POOL];
    logic [btpt_pkg::IDX_W-1:0] r_rd_data;
    logic [btpt_pkg::CNT_W-1:0] r_top;
    logic [btpt_pkg::CNT_W-1:0] n_top;
    logic [btpt_pkg::CNT_W-1:0] w_top_m1;

    assign w_top_m1 = r_top - 1'b1;

    always_comb begin
        n_top = r_top;
        if (i_ctl.pop) begin
            n_top = w_top_m1;
        end else if (i_ctl.push && r_top < btpt_pkg::CNT_W'(btpt_pkg::NODE_POOL)) begin
            n_top = r_top + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= btpt_pkg::CNT_W'(btpt_pkg::NODE_POOL - 1);
        end else begin
            r_top <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_we) begin
            r_mem[i_ctl.clr_idx] <= ~i_ctl.clr_idx;
        end else if (i_ctl.push && r_top < btpt_pkg::CNT_W'(btpt_pkg::NODE_POOL)) begin
            r_mem[r_top[btpt_pkg::IDX_W-1:0]] <= i_ctl.push_data;
        end
        if (i_ctl.pop_rd) begin
            r_rd_data <= r_mem[w_top_m1[btpt_pkg::IDX_W-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_top     = r_top;

endmodule
`default_nettype wire

// ===== rtl/btpt_engine.sv =====
`default_nettype none
module btpt_engine (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire  [btpt_pkg::CMD_W-1:0]      i_cmd,
    input  wire  [btpt_pkg::ADDR_BITS-1:0]  i_address,
    input  wire  [btpt_pkg::LEN_W-1:0]      i_prefix_len,
    input  wire  [btpt_pkg::CODE_W-1:0]     i_action_code,
    output logic                            o_valid,
    input  wire                             i_out_ready,
    output logic [btpt_pkg::STAT_W-1:0]     o_status,
    output logic [btpt_pkg::CODE_W-1:0]     o_found_action,
    output logic [btpt_pkg::LEN_W-1:0]      o_match_depth,
    output logic [btpt_pkg::CNT_W-1:0]      o_node_count,
    output btpt_pkg::t_node_ctl             o_node_ctl,
    input  btpt_pkg::t_node                 i_node_rdata,
    output btpt_pkg::t_free_ctl             o_free_ctl,
    input  wire  [btpt_pkg::IDX_W-1:0]      i_free_rdata,
    input  wire  [btpt_pkg::CNT_W-1:0]      i_free_top
);

    btpt_pkg::t_state r_state, n_state;

    logic [btpt_pkg::IDX_W-1:0]     r_clr_idx;
    logic [btpt_pkg::CMD_W-1:0]     r_cmd;
    logic [btpt_pkg::ADDR_BITS-1:0] r_addr;
    logic [btpt_pkg::LEN_W-1:0]     r_len;
    logic [btpt_pkg::CODE_W-1:0]    r_code;
    logic [btpt_pkg::IDX_W-1:0]     r_cur, n_cur;
    logic [btpt_pkg::IDX_W-1:0]     r_prev, n_prev;
    btpt_pkg::t_node                r_rec, n_rec;
    logic [btpt_pkg::LEN_W-1:0]     r_d, n_d;
    logic                           r_hit, n_hit;
    logic [btpt_pkg::IDX_W-1:0]     r_best, n_best;
    btpt_pkg::t_node                r_best_rec, n_best_rec;
    logic [btpt_pkg::LEN_W-1:0]     r_best_d, n_best_d;
    logic [btpt_pkg::STAT_W-1:0]    r_res_status, n_res_status;
    logic [btpt_pkg::CODE_W-1:0]    r_res_action, n_res_action;
    logic [btpt_pkg::LEN_W-1:0]     r_res_depth, n_res_depth;
    logic                           r_ovalid;
    logic [btpt_pkg::STAT_W-1:0]    r_o_status;
    logic [btpt_pkg::CODE_W-1:0]    r_o_action;
    logic [btpt_pkg::LEN_W-1:0]     r_o_depth;
    logic [btpt_pkg::CNT_W-1:0]     r_o_count;

    logic                           w_bit;
    logic [btpt_pkg::IDX_W-1:0]     w_child;
    logic                           w_hit_now;
    logic                           w_hit_all;
    btpt_pkg::t_node                w_best_rec;
    logic [btpt_pkg::LEN_W-1:0]     w_need;
    logic [btpt_pkg::ACT_W-1:0]     w_code_act;
    logic                           w_load_out;
    logic [btpt_pkg::LEN_W-1:0]     w_len_sat;

    assign w_bit      = r_addr[5'(btpt_pkg::ADDR_BITS - 1) - r_d[4:0]];
    assign w_child    = w_bit ? i_node_rdata.child1 : i_node_rdata.child0;
    assign w_hit_now  = i_node_rdata.action != '0;
    assign w_hit_all  = r_hit | w_hit_now;
    assign w_best_rec = w_hit_now ? i_node_rdata : r_best_rec;
    assign w_need     = r_len - r_d;
    assign w_code_act = {1'b0, r_code} + 1'b1;
    assign w_len_sat  = (i_prefix_len > btpt_pkg::LEN_W'(btpt_pkg::ADDR_BITS)) ?
                        btpt_pkg::LEN_W'(btpt_pkg::ADDR_BITS) : i_prefix_len;
    assign w_load_out = (r_state == btpt_pkg::S_DONE) && (!r_ovalid || i_out_ready);
    assign o_ready    = r_state == btpt_pkg::S_IDLE;

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_rec        = r_rec;
        n_d          = r_d;
        n_hit        = r_hit;
        n_best       = r_best;
        n_best_rec   = r_best_rec;
        n_best_d     = r_best_d;
        n_res_status = r_res_status;
        n_res_action = r_res_action;
        n_res_depth  = r_res_depth;
        o_node_ctl   = '0;
        o_free_ctl   = '0;
        unique case (r_state)
            btpt_pkg::S_CLEAR: begin
                o_node_ctl.we      = 1'b1;
                o_node_ctl.waddr   = r_clr_idx;
                o_free_ctl.clr_we  = 1'b1;
                o_free_ctl.clr_idx = r_clr_idx;
                if (r_clr_idx == btpt_pkg::IDX_W'(btpt_pkg::NODE_POOL - 1)) begin
                    n_state = btpt_pkg::S_IDLE;
                end
            end
            btpt_pkg::S_IDLE: begin
                n_cur        = '0;
                n_d          = '0;
                n_hit        = 1'b0;
                n_best       = '0;
                n_best_d     = '0;
                n_res_status = btpt_pkg::ST_NOTFOUND;
                n_res_action = '0;
                n_res_depth  = '0;
                if (i_valid) begin
                    if (i_cmd == btpt_pkg::CMD_ADD || i_cmd == btpt_pkg::CMD_FIND ||
                        i_cmd == btpt_pkg::CMD_REMOVE) begin
                        o_node_ctl.re    = 1'b1;
                        o_node_ctl.raddr = '0;
                        n_state          = btpt_pkg::S_WALK;
                    end else begin
                        n_state = btpt_pkg::S_DONE;
                    end
                end
            end
            btpt_pkg::S_WALK: begin
                if (r_cmd == btpt_pkg::CMD_ADD) begin
                    if (r_d < r_len && w_child != '0) begin
                        o_node_ctl.re    = 1'b1;
                        o_node_ctl.raddr = w_child;
                        n_cur            = w_child;
                        n_d              = r_d + 1'b1;
                    end else if (btpt_pkg::CNT_W'(w_need) > i_free_top) begin
                        n_res_status = btpt_pkg::ST_FULL;
                        n_state      = btpt_pkg::S_DONE;
                    end else if (r_d == r_len) begin
                        o_node_ctl.we           = 1'b1;
                        o_node_ctl.waddr        = r_cur;
                        o_node_ctl.wdata        = i_node_rdata;
                        o_node_ctl.wdata.action = w_code_act;
                        n_res_status            = btpt_pkg::ST_OK;
                        n_res_depth             = r_len;
                        n_state                 = btpt_pkg::S_DONE;
                    end else begin
                        n_rec   = i_node_rdata;
                        n_state = btpt_pkg::S_POP;
                    end
                end else begin
                    n_hit = w_hit_all;
                    if (w_hit_now) begin
                        n_best     = r_cur;
                        n_best_rec = i_node_rdata;
                        n_best_d   = r_d;
                    end
                    if (!r_d[5] && w_child != '0) begin
                        o_node_ctl.re    = 1'b1;
                        o_node_ctl.raddr = w_child;
                        n_cur            = w_child;
                        n_d              = r_d + 1'b1;
                    end else begin
                        n_state = btpt_pkg::S_DONE;
                        if (r_cmd == btpt_pkg::CMD_FIND) begin
                            if (w_hit_all) begin
                                n_res_status = btpt_pkg::ST_OK;
                                n_res_action = btpt_pkg::CODE_W'(w_best_rec.action - 1'b1);
                                n_res_depth  = w_hit_now ? r_d : r_best_d;
                            end
                        end else if (w_hit_all && w_best_rec.action == w_code_act) begin
                            n_res_status = btpt_pkg::ST_OK;
                            n_res_depth  = w_hit_now ? r_d : r_best_d;
                            n_cur        = w_hit_now ? r_cur : r_best;
                            n_rec        = w_best_rec;
                            n_rec.action = '0;
                            n_state      = btpt_pkg::S_PRUNE;
                        end
                    end
                end
            end
            btpt_pkg::S_POP: begin
                o_free_ctl.pop_rd = 1'b1;
                n_state           = btpt_pkg::S_ALLOC;
            end
            btpt_pkg::S_ALLOC: begin
                o_free_ctl.pop   = 1'b1;
                o_node_ctl.we    = 1'b1;
                o_node_ctl.waddr = r_cur;
                o_node_ctl.wdata = r_rec;
                if (w_bit) begin
                    o_node_ctl.wdata.child1 = i_free_rdata;
                end else begin
                    o_node_ctl.wdata.child0 = i_free_rdata;
                end
                n_rec        = '0;
                n_rec.parent = r_cur;
                n_cur        = i_free_rdata;
                n_d          = r_d + 1'b1;
                n_state      = (r_d + 1'b1 == r_len) ? btpt_pkg::S_ADD_FIN : btpt_pkg::S_POP;
            end
            btpt_pkg::S_ADD_FIN: begin
                o_node_ctl.we           = 1'b1;
                o_node_ctl.waddr        = r_cur;
                o_node_ctl.wdata        = r_rec;
                o_node_ctl.wdata.action = w_code_act;
                n_res_status            = btpt_pkg::ST_OK;
                n_res_depth             = r_len;
                n_state                 = btpt_pkg::S_DONE;
            end
            btpt_pkg::S_PRUNE: begin
                if (r_cur != '0 && r_rec.child0 == '0 && r_rec.child1 == '0 &&
                    r_rec.action == '0) begin
                    o_node_ctl.re        = 1'b1;
                    o_node_ctl.raddr     = r_rec.parent;
                    o_free_ctl.push      = 1'b1;
                    o_free_ctl.push_data = r_cur;
                    n_prev               = r_cur;
                    n_cur                = r_rec.parent;
                    n_state              = btpt_pkg::S_PRUNE_UP;
                end else begin
                    o_node_ctl.we    = 1'b1;
                    o_node_ctl.waddr = r_cur;
                    o_node_ctl.wdata = r_rec;
                    n_state          = btpt_pkg::S_DONE;
                end
            end
            btpt_pkg::S_PRUNE_UP: begin
                n_rec = i_node_rdata;
                if (i_node_rdata.child0 == r_prev) begin
                    n_rec.child0 = '0;
                end
                if (i_node_rdata.child1 == r_prev) begin
                    n_rec.child1 = '0;
                end
                n_state = btpt_pkg::S_PRUNE;
            end
            btpt_pkg::S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_state = btpt_pkg::S_IDLE;
                end
            end
            default: n_state = btpt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= btpt_pkg::S_CLEAR;
            r_clr_idx <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == btpt_pkg::S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == btpt_pkg::S_IDLE && i_valid) begin
            r_cmd  <= i_cmd;
            r_addr <= i_address;
            r_len  <= w_len_sat;
            r_code <= i_action_code;
        end
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_rec        <= n_rec;
        r_d          <= n_d;
        r_hit        <= n_hit;
        r_best       <= n_best;
        r_best_rec   <= n_best_rec;
        r_best_d     <= n_best_d;
        r_res_status <= n_res_status;
        r_res_action <= n_res_action;
        r_res_depth  <= n_res_depth;
        if (w_load_out) begin
            r_o_status <= r_res_status;
            r_o_action <= r_res_action;
            r_o_depth  <= r_res_depth;
            r_o_count  <= btpt_pkg::CNT_W'(btpt_pkg::NODE_POOL) - i_free_top;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_o_status;
    assign o_found_action = r_o_action;
    assign o_match_depth  = r_o_depth;
    assign o_node_count   = r_o_count;

endmodule
`default_nettype wire

// ===== rtl/binary_trie_prefix_table.sv =====
`default_nettype none
// Longest-prefix-match table for IPv4 addresses, held as a binary trie in a
// 1024-node pool with a free-node stack. After reset the block runs a
// clearing pass over both memories and accepts no beat until it ends. One
// operation is handled at a time: a trie walk reads one node per level
// visited, each newly allocated node adds a free-stack read and a node write,
// each pruned node adds a free-stack push and a read of its parent, and the
// accept, the result and, where needed, a final write-back complete it. A
// finished result that waits on m_axis_tready holds the block until taken.
// The single read port of the node memory, whose read is registered, paces
// every step of the walk. Commands on s_axis_tuser are add (0), find (1) and
// remove (2); status on m_axis_tuser is ok (0), not found (1) or pool full
// (2).
module binary_trie_prefix_table (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // address, prefix_len, action_code
    input  wire  [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // found_action, match_depth, node_count
    output logic [1:0]  m_axis_tuser    // status
);

    btpt_pkg::t_node_ctl              w_node_ctl;
    btpt_pkg::t_node                  w_node_rdata;
    btpt_pkg::t_free_ctl              w_free_ctl;
    logic [btpt_pkg::IDX_W-1:0]       w_free_rdata;
    logic [btpt_pkg::CNT_W-1:0]       w_free_top;
    logic [btpt_pkg::CODE_W-1:0]      w_found_action;
    logic [btpt_pkg::LEN_W-1:0]       w_match_depth;
    logic [btpt_pkg::CNT_W-1:0]       w_node_count;

    btpt_node_store u_node_store (
        .i_clk   (i_clk),
        .i_ctl   (w_node_ctl),
        .o_rdata (w_node_rdata)
    );

    btpt_free_stack u_free_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_free_ctl),
        .o_rd_data (w_free_rdata),
        .o_top     (w_free_top)
    );

    btpt_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_cmd          (s_axis_tuser),
        .i_address      (s_axis_tdata[31:0]),
        .i_prefix_len   (s_axis_tdata[37:32]),
        .i_action_code  (s_axis_tdata[42:38]),
        .o_valid        (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_status       (m_axis_tuser),
        .o_found_action (w_found_action),
        .o_match_depth  (w_match_depth),
        .o_node_count   (w_node_count),
        .o_node_ctl     (w_node_ctl),
        .i_node_rdata   (w_node_rdata),
        .o_free_ctl     (w_free_ctl),
        .i_free_rdata   (w_free_rdata),
        .i_free_top     (w_free_top)
    );

    assign m_axis_tdata = {2'b00, w_node_count, w_match_depth, w_found_action};

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_free_top <= btpt_pkg::CNT_W'(btpt_pkg::NODE_POOL - 1))
        else $error("free stack count exceeds pool");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_node_ctl.we && w_node_ctl.re && w_node_ctl.waddr == w_node_ctl.raddr))
        else $error("node memory read and write hit one entry");

    a_pop_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_free_ctl.pop && w_free_ctl.push))
        else $error("free stack pop and push together");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_node_count != '0)
        else $error("node count dropped to zero");

endmodule
`default_nettype wire
